### rtl/hcd_pkg.sv
`timescale 1ns / 1ps
// hcd_pkg: types and constants for the header/checksum deframer.
// Used by every module under rtl/. No dependencies.
package hcd_pkg;

	localparam int FRAME_LEN = 8;
	localparam int IDX_W = $clog2(FRAME_LEN);
	localparam int POS_W = 6;
	localparam int CNT_W = 32;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
	localparam logic [7:0] HEADER_RESET = 8'h5A;

	// command queue depth, power of two
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

	localparam int PADDR_W = 3;
	localparam logic REG_HEADER = 1'b0;

	typedef enum logic [2:0] {
		ST_STORED     = 3'd0,
		ST_HDR_REJ    = 3'd1,
		ST_TIMEOUT    = 3'd2,
		ST_FRAME_BYTE = 3'd3,
		ST_RESYNC     = 3'd4
	} status_t;

	typedef struct packed {
		logic       timed_out;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [7:0]       data_byte;
		logic [POS_W-1:0] byte_pos;
		logic             last;
		logic [CNT_W-1:0] valid_count;
		logic [CNT_W-1:0] header_err_count;
		logic [CNT_W-1:0] check_err_count;
		logic [CNT_W-1:0] timeout_count;
	} out_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] valid_frames;
		logic [CNT_W-1:0] header_errors;
		logic [CNT_W-1:0] checksum_errors;
		logic [CNT_W-1:0] timeouts;
	} counters_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// one classified item: either a single result or a whole good frame
	typedef struct packed {
		logic             emit_frame;
		status_t          status;
		logic [POS_W-1:0] pos;
		counters_t        cnt;
		frame_t           frame;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

### rtl/header_checksum_deframer.sv
`timescale 1ns / 1ps
// header_checksum_deframer: fixed-length frame sync with additive checksum.
// An item is classified in the cycle it is accepted, then passes the command
// queue, command register and output register. One item per cycle while the
// two-entry command queue has room; the back end gives one result per cycle
// while results are popped, FRAME_LEN for a good frame. Asynchronous
// reset clears fill level, counters and queue; header_value resets to 0x5A.
module header_checksum_deframer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  hcd_pkg::in_item_t                item,
	output logic                             empty,
	input  logic                             pop,
	output hcd_pkg::out_item_t               result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hcd_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	logic               in_fire;
	logic [7:0]         header_q;
	logic               cmd_wr;
	hcd_pkg::cmd_t      cmd;
	hcd_pkg::cmd_t      qdata;
	hcd_pkg::q_status_t qstat;
	logic               qrd;

	assign pready = 1'b1;
	assign in_fire = push && !qstat.full;
	assign full = qstat.full;
	assign prdata = (paddr[2] == hcd_pkg::REG_HEADER) ? {24'd0, header_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= hcd_pkg::HEADER_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == hcd_pkg::REG_HEADER) begin
			header_q <= pwdata[7:0];
		end
	end

	hcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.item         (item),
		.header_value (header_q),
		.cmd_wr       (cmd_wr),
		.cmd          (cmd)
	);

	hcd_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd),
		.rd     (qrd),
		.rdata  (qdata),
		.stat   (qstat)
	);

	hcd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.qdata  (qdata),
		.qrd    (qrd),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule

### rtl/hcd_front.sv
`timescale 1ns / 1ps
// hcd_front: accepts items, keeps the frame store, fill level and counters,
// and classifies each item into a command. Depends on hcd_pkg.
module hcd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  hcd_pkg::in_item_t item,
	input  logic [7:0]        header_value,
	output logic              cmd_wr,
	output hcd_pkg::cmd_t     cmd
);

	hcd_pkg::frame_t                store_q;
	hcd_pkg::frame_t                store_n;
	hcd_pkg::frame_t                frame;
	hcd_pkg::frame_t                shifted;
	logic [hcd_pkg::IDX_W-1:0]      fill_q;
	logic [hcd_pkg::IDX_W-1:0]      fill_n;
	logic [hcd_pkg::IDX_W-1:0]      idx;
	hcd_pkg::counters_t             cnt_q;
	hcd_pkg::counters_t             cnt_n;
	logic [7:0]                     sum;
	logic                           hit;
	logic                           good;

	always_comb begin
		frame = store_q;
		frame[hcd_pkg::LAST_IDX] = item.rx_byte;
		sum = '0;
		for (int k = 0; k < hcd_pkg::FRAME_LEN - 1; k++) begin
			sum = sum + frame[k];
		end
		good = (frame[0] == header_value) && (sum == item.rx_byte);
		hit = 1'b0;
		idx = '0;
		for (int k = hcd_pkg::FRAME_LEN - 1; k >= 1; k--) begin
			if (frame[k] == header_value) begin
				hit = 1'b1;
				idx = hcd_pkg::IDX_W'(k);
			end
		end
		shifted = frame >> {idx, 3'b000};
	end

	always_comb begin
		cnt_n = cnt_q;
		fill_n = fill_q;
		store_n = store_q;
		cmd = '0;
		cmd.frame = frame;
		priority if (item.timed_out) begin
			cnt_n.timeouts = cnt_q.timeouts + 1'b1;
			cmd.status = hcd_pkg::ST_TIMEOUT;
		end else if (fill_q == '0 && item.rx_byte != header_value) begin
			cnt_n.header_errors = cnt_q.header_errors + 1'b1;
			cmd.status = hcd_pkg::ST_HDR_REJ;
		end else if (fill_q != hcd_pkg::LAST_IDX) begin
			store_n[fill_q] = item.rx_byte;
			fill_n = fill_q + 1'b1;
			cmd.status = hcd_pkg::ST_STORED;
			cmd.pos = hcd_pkg::POS_W'(fill_q);
		end else if (good) begin
			cnt_n.valid_frames = cnt_q.valid_frames + 1'b1;
			fill_n = '0;
			cmd.emit_frame = 1'b1;
			cmd.status = hcd_pkg::ST_FRAME_BYTE;
		end else begin
			cnt_n.checksum_errors = cnt_q.checksum_errors + 1'b1;
			store_n = shifted;
			fill_n = hit ? hcd_pkg::IDX_W'(hcd_pkg::FRAME_LEN - int'(idx)) : '0;
			cmd.status = hcd_pkg::ST_RESYNC;
		end
		cmd.cnt = cnt_n;
	end

	assign cmd_wr = in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			cnt_q <= '0;
		end else if (in_fire) begin
			fill_q <= fill_n;
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			store_q <= store_n;
		end
	end

endmodule

### rtl/hcd_cmd_fifo.sv
`timescale 1ns / 1ps
// hcd_cmd_fifo: short command queue between front and back.
// Depends on hcd_pkg.
module hcd_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  hcd_pkg::cmd_t      wdata,
	input  logic               rd,
	output hcd_pkg::cmd_t      rdata,
	output hcd_pkg::q_status_t stat
);

	hcd_pkg::cmd_t               entry_q [hcd_pkg::CMDQ_DEPTH];
	logic [hcd_pkg::CMDQ_AW-1:0] wptr_q;
	logic [hcd_pkg::CMDQ_AW-1:0] rptr_q;
	logic [hcd_pkg::CMDQ_CW-1:0] count_q;

	assign stat.full = (count_q == hcd_pkg::CMDQ_CW'(hcd_pkg::CMDQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wptr_q] <= wdata;
		end
	end

endmodule

### rtl/hcd_back.sv
`timescale 1ns / 1ps
// hcd_back: expands queued commands into result transfers, one per cycle
// while results are popped, through an output register. Depends on hcd_pkg.
module hcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hcd_pkg::q_status_t  qstat,
	input  hcd_pkg::cmd_t       qdata,
	output logic                qrd,
	input  logic                pop,
	output logic                empty,
	output hcd_pkg::out_item_t  result
);

	hcd_pkg::cmd_t             cur_q;
	logic                      busy_q;
	logic [hcd_pkg::IDX_W-1:0] beat_q;
	logic                      out_valid_q;
	hcd_pkg::out_item_t        out_q;
	hcd_pkg::out_item_t        nxt;
	logic                      load_out;
	logic                      last_beat;

	assign load_out = !out_valid_q || pop;
	assign last_beat = !cur_q.emit_frame || (beat_q == hcd_pkg::LAST_IDX);
	assign qrd = !qstat.empty && (!busy_q || (load_out && last_beat));

	always_comb begin
		nxt.status = cur_q.status;
		nxt.valid_count = cur_q.cnt.valid_frames;
		nxt.header_err_count = cur_q.cnt.header_errors;
		nxt.check_err_count = cur_q.cnt.checksum_errors;
		nxt.timeout_count = cur_q.cnt.timeouts;
		nxt.last = last_beat;
		if (cur_q.emit_frame) begin
			nxt.data_byte = cur_q.frame[beat_q];
			nxt.byte_pos = hcd_pkg::POS_W'(beat_q);
		end else begin
			nxt.data_byte = '0;
			nxt.byte_pos = cur_q.pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= busy_q;
			end
			if (qrd) begin
				busy_q <= 1'b1;
				beat_q <= '0;
			end else if (busy_q && load_out) begin
				if (last_beat) begin
					busy_q <= 1'b0;
					beat_q <= '0;
				end else begin
					beat_q <= beat_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (qrd) begin
			cur_q <= qdata;
		end
		if (busy_q && load_out) begin
			out_q <= nxt;
		end
	end

	assign empty = !out_valid_q;
	assign result = out_q;

endmodule
